// ----- src/kst_pkg.sv -----
package kst_pkg;

    // ring and queue sizing
    localparam int KST_RING_DEPTH = 512;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW       = $clog2(QUEUE_DEPTH + 1);

    // set-1 scancodes with special handling
    localparam logic [7:0] K_LSHIFT    = 8'h2A;
    localparam logic [7:0] K_RSHIFT    = 8'h36;
    localparam logic [7:0] K_CTRL      = 8'h1D;
    localparam logic [7:0] K_ALT       = 8'h38;
    localparam logic [7:0] K_CAPS      = 8'h3A;
    localparam logic [7:0] K_NUM       = 8'h45;
    localparam logic [7:0] K_SCROLL    = 8'h46;
    localparam logic [7:0] K_TABLE_END = 8'h58;
    localparam int         MAP_SIZE    = 88;

    // flag bits
    localparam logic [2:0] MOD_SHIFT   = 3'b001;
    localparam logic [2:0] MOD_CTRL    = 3'b010;
    localparam logic [2:0] MOD_ALT     = 3'b100;
    localparam logic [2:0] LOCK_CAPS   = 3'b100;
    localparam logic [2:0] LOCK_NUM    = 3'b010;
    localparam logic [2:0] LOCK_SCROLL = 3'b001;

    localparam logic [7:0] RELEASE_BIT = 8'h80;
    localparam logic [7:0] CASE_DELTA  = 8'd32;

    // plain key map
    localparam logic [7:0] PLAIN_MAP [0:MAP_SIZE-1] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
        8'h2D, 8'h3D, 8'h00, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h00, 8'h00, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68,
        8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h0F, 8'h20, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1B, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00
    };

    // shifted key map
    localparam logic [7:0] UPPER_MAP [0:MAP_SIZE-1] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
        8'h5F, 8'h2B, 8'h00, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h00, 8'h00, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48,
        8'h4A, 8'h4B, 8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h0F, 8'h20, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1B, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00
    };

    // work kinds handed from front to back
    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] scan;
        logic [7:0] ch_byte;
        logic       has_char;
        logic       led_write;
        logic [2:0] led_value;
        logic [2:0] mods;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POP
    } t_back_state;

    // table lookup with caps and ctrl adjustments
    function automatic logic [7:0] f_translate(
        input logic [7:0] code,
        input logic       sh,
        input logic       caps,
        input logic       ctrl
    );
        logic [7:0] c;
        c = 8'h00;
        if (code < K_TABLE_END) begin
            c = sh ? UPPER_MAP[code[6:0]] : PLAIN_MAP[code[6:0]];
        end
        if (caps && c >= 8'h61 && c <= 8'h7A) begin
            c = c - CASE_DELTA;
        end else if (caps && c >= 8'h41 && c <= 8'h5A && !sh) begin
            c = c + CASE_DELTA;
        end
        if (ctrl && c >= 8'h61 && c <= 8'h7A) begin
            c = c - 8'h60;
        end
        return c;
    endfunction

endpackage

// ----- src/kst_ram.sv -----
module kst_ram import kst_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = KST_RING_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // single write port, registered read that holds between reads
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/kst_front.sv -----
module kst_front import kst_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_action,
    input  logic [7:0] i_scan_byte,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_cmd       o_q_cmd
);

    logic [2:0] r_mods;
    logic [2:0] r_locks;
    logic [2:0] n_mods;
    logic [2:0] n_locks;
    logic       accept;
    logic       led_write;
    logic       is_push;
    logic [6:0] code;
    logic [7:0] ch_byte;

    assign accept = i_in_valid && !i_q_full;
    assign code   = i_scan_byte[6:0];

    // classify the beat and update modifier and lock flags
    always_comb begin
        n_mods    = r_mods;
        n_locks   = r_locks;
        led_write = 1'b0;
        is_push   = 1'b0;
        if (i_action) begin
            // pop request, flags untouched
        end else if ((i_scan_byte & RELEASE_BIT) != 8'h00) begin
            if ({1'b0, code} == K_LSHIFT || {1'b0, code} == K_RSHIFT) begin
                n_mods = r_mods & ~MOD_SHIFT;
            end else if ({1'b0, code} == K_CTRL) begin
                n_mods = r_mods & ~MOD_CTRL;
            end else if ({1'b0, code} == K_ALT) begin
                n_mods = r_mods & ~MOD_ALT;
            end
        end else if (i_scan_byte == K_LSHIFT || i_scan_byte == K_RSHIFT) begin
            n_mods = r_mods | MOD_SHIFT;
        end else if (i_scan_byte == K_CTRL) begin
            n_mods = r_mods | MOD_CTRL;
        end else if (i_scan_byte == K_ALT) begin
            n_mods = r_mods | MOD_ALT;
        end else if (i_scan_byte == K_CAPS) begin
            n_locks   = r_locks ^ LOCK_CAPS;
            led_write = 1'b1;
        end else if (i_scan_byte == K_NUM) begin
            n_locks   = r_locks ^ LOCK_NUM;
            led_write = 1'b1;
        end else if (i_scan_byte == K_SCROLL) begin
            n_locks   = r_locks ^ LOCK_SCROLL;
            led_write = 1'b1;
        end else begin
            is_push = 1'b1;
        end
    end

    // character for a plain key press
    assign ch_byte = f_translate(i_scan_byte, (r_mods & MOD_SHIFT) != 3'b000,
                                 (r_locks & LOCK_CAPS) != 3'b000,
                                 (r_mods & MOD_CTRL) != 3'b000);

    // queue entry
    always_comb begin
        if (i_action) begin
            o_q_cmd.op = OP_POP;
        end else if (is_push) begin
            o_q_cmd.op = OP_PUSH;
        end else begin
            o_q_cmd.op = OP_NONE;
        end
        o_q_cmd.scan      = i_scan_byte;
        o_q_cmd.ch_byte   = ch_byte;
        o_q_cmd.has_char  = ch_byte != 8'h00;
        o_q_cmd.led_write = led_write;
        o_q_cmd.led_value = n_locks;
        o_q_cmd.mods      = n_mods;
    end

    // flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mods  <= '0;
            r_locks <= '0;
        end else if (accept) begin
            r_mods  <= n_mods;
            r_locks <= n_locks;
        end
    end

    assign o_q_push   = accept;
    assign o_in_stall = i_q_full;

endmodule

// ----- src/kst_queue.sv -----
module kst_queue import kst_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_head_valid,
    output t_cmd o_head_cmd
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_idx;
    logic [QUEUE_AW-1:0] r_rd_idx;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full       = r_count == QUEUE_CW'(QUEUE_DEPTH);
    assign o_head_valid = r_count != '0;
    assign o_head_cmd   = r_mem[r_rd_idx];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_idx] <= i_push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_idx <= r_wr_idx + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_idx <= r_rd_idx + QUEUE_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QUEUE_CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QUEUE_CW'(1);
            end
        end
    end

endmodule

// ----- src/kst_back.sv -----
module kst_back import kst_pkg::*; #(
    parameter int RING_DEPTH = KST_RING_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_led_write,
    output logic [2:0] o_led_value,
    output logic       o_pop_valid,
    output logic [7:0] o_pop_byte,
    output logic       o_event_pressed,
    output logic [6:0] o_event_code,
    output logic       o_shift_down,
    output logic       o_ctrl_down,
    output logic       o_alt_down,
    output logic       o_dropped_oldest
);

    localparam int             PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_DEPTH - 1);

    t_back_state      r_state;
    t_back_state      n_state;
    t_cmd             r_cur;
    t_cmd             n_cur;
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [PTR_W-1:0] n_wp;
    logic [PTR_W-1:0] n_rp;
    logic [PTR_W-1:0] wp_inc;
    logic [PTR_W-1:0] rp_inc;
    logic             r_drop;
    logic             n_drop;
    logic             r_hit;
    logic             n_hit;
    logic             full;
    logic             out_free;
    logic             out_load;
    logic             wr_en;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [7:0]       rd_data;

    // result register
    logic       r_out_valid;
    logic       r_led_write;
    logic [2:0] r_led_value;
    logic [7:0] r_pop_byte;
    logic [2:0] r_mods;
    logic       r_dropped;
    logic       n_led_write;
    logic [2:0] n_led_value;
    logic [7:0] n_pop_byte;
    logic [2:0] n_mods;
    logic       n_dropped;

    kst_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rp),
        .o_rd_data (rd_data)
    );

    // ring pointer arithmetic
    assign wp_inc   = (r_wp == LAST) ? '0 : r_wp + PTR_W'(1);
    assign rp_inc   = (r_rp == LAST) ? '0 : r_rp + PTR_W'(1);
    assign full     = wp_inc == r_rp;
    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && i_q_cmd.op == OP_PUSH && i_q_cmd.has_char) begin
                    n_state = S_SCAN;
                end else if (i_q_valid && i_q_cmd.op == OP_POP) begin
                    n_state = S_POP;
                end
            end
            S_SCAN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_POP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ring accesses and result loading
    always_comb begin
        o_q_pop     = 1'b0;
        wr_en       = 1'b0;
        wr_data     = r_cur.scan;
        rd_en       = 1'b0;
        out_load    = 1'b0;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_cur       = r_cur;
        n_drop      = r_drop;
        n_hit       = r_hit;
        n_led_write = r_led_write;
        n_led_value = r_led_value;
        n_pop_byte  = r_pop_byte;
        n_mods      = r_mods;
        n_dropped   = r_dropped;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_cmd.op)
                        OP_PUSH: begin
                            if (i_q_cmd.has_char) begin
                                // character first, scancode written later in S_SCAN
                                o_q_pop = 1'b1;
                                wr_en   = 1'b1;
                                wr_data = i_q_cmd.ch_byte;
                                n_wp    = wp_inc;
                                n_rp    = full ? rp_inc : r_rp;
                                n_drop  = full;
                                n_cur   = i_q_cmd;
                            end else if (out_free) begin
                                o_q_pop     = 1'b1;
                                wr_en       = 1'b1;
                                wr_data     = i_q_cmd.scan;
                                n_wp        = wp_inc;
                                n_rp        = full ? rp_inc : r_rp;
                                out_load    = 1'b1;
                                n_led_write = i_q_cmd.led_write;
                                n_led_value = i_q_cmd.led_value;
                                n_mods      = i_q_cmd.mods;
                                n_pop_byte  = 8'h00;
                                n_dropped   = full;
                            end
                        end
                        OP_POP: begin
                            o_q_pop = 1'b1;
                            n_cur   = i_q_cmd;
                            n_hit   = r_rp != r_wp;
                            if (r_rp != r_wp) begin
                                rd_en = 1'b1;
                                n_rp  = rp_inc;
                            end
                        end
                        default: begin
                            // modifier, lock or release beat
                            if (out_free) begin
                                o_q_pop     = 1'b1;
                                out_load    = 1'b1;
                                n_led_write = i_q_cmd.led_write;
                                n_led_value = i_q_cmd.led_value;
                                n_mods      = i_q_cmd.mods;
                                n_pop_byte  = 8'h00;
                                n_dropped   = 1'b0;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (out_free) begin
                    wr_en       = 1'b1;
                    wr_data     = r_cur.scan;
                    n_wp        = wp_inc;
                    n_rp        = full ? rp_inc : r_rp;
                    out_load    = 1'b1;
                    n_led_write = r_cur.led_write;
                    n_led_value = r_cur.led_value;
                    n_mods      = r_cur.mods;
                    n_pop_byte  = 8'h00;
                    n_dropped   = r_drop || full;
                end
            end
            S_POP: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    n_led_write = r_cur.led_write;
                    n_led_value = r_cur.led_value;
                    n_mods      = r_cur.mods;
                    n_pop_byte  = r_hit ? rd_data : 8'h00;
                    n_dropped   = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_out_valid <= out_load || (r_out_valid && i_out_stall);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_drop <= n_drop;
        r_hit  <= n_hit;
        if (out_load) begin
            r_led_write <= n_led_write;
            r_led_value <= n_led_value;
            r_pop_byte  <= n_pop_byte;
            r_mods      <= n_mods;
            r_dropped   <= n_dropped;
        end
    end

    // result fields
    assign o_out_valid      = r_out_valid;
    assign o_led_write      = r_led_write;
    assign o_led_value      = r_led_value;
    assign o_pop_valid      = r_pop_byte != 8'h00;
    assign o_pop_byte       = r_pop_byte;
    assign o_event_pressed  = (r_pop_byte != 8'h00) && !r_pop_byte[7];
    assign o_event_code     = r_pop_byte[6:0];
    assign o_shift_down     = (r_mods & MOD_SHIFT) != 3'b000;
    assign o_ctrl_down      = (r_mods & MOD_CTRL) != 3'b000;
    assign o_alt_down       = (r_mods & MOD_ALT) != 3'b000;
    assign o_dropped_oldest = r_dropped;

endmodule

// ----- src/keyboard_scancode_translator_fifo.sv -----
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_stall    i_action, i_scan_byte
// output    out        o_out_valid / i_out_stall  o_led_write .. o_dropped_oldest
//
// A key press with a character is split in the ring stage: the character and the
// scancode go through the single ring write port one after the other (S_IDLE, S_SCAN).
// A pop adds S_POP for the registered ring read; every other beat is handled in S_IDLE.
// A 4-entry command queue sits between classifier and ring stage; o_in_stall rises
// only when it is full. Synchronous active-low reset clears flags, pointers and queue;
// ring contents are not cleared and need no clearing pass.
module keyboard_scancode_translator_fifo import kst_pkg::*; #(
    parameter int RING_DEPTH = KST_RING_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_action,
    input  logic [7:0] i_scan_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_led_write,
    output logic [2:0] o_led_value,
    output logic       o_pop_valid,
    output logic [7:0] o_pop_byte,
    output logic       o_event_pressed,
    output logic [6:0] o_event_code,
    output logic       o_shift_down,
    output logic       o_ctrl_down,
    output logic       o_alt_down,
    output logic       o_dropped_oldest
);

    logic q_push;
    t_cmd q_push_cmd;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_cmd q_head_cmd;

    // classifier with modifier and lock state
    kst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_scan_byte (i_scan_byte),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_push_cmd)
    );

    // command queue between the two halves
    kst_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_cmd   (q_push_cmd),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_head_valid (q_valid),
        .o_head_cmd   (q_head_cmd)
    );

    // ring stage and result register
    kst_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_cmd          (q_head_cmd),
        .o_q_pop          (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_led_write      (o_led_write),
        .o_led_value      (o_led_value),
        .o_pop_valid      (o_pop_valid),
        .o_pop_byte       (o_pop_byte),
        .o_event_pressed  (o_event_pressed),
        .o_event_code     (o_event_code),
        .o_shift_down     (o_shift_down),
        .o_ctrl_down      (o_ctrl_down),
        .o_alt_down       (o_alt_down),
        .o_dropped_oldest (o_dropped_oldest)
    );

endmodule

// ----- sim/tb_keyboard_scancode_translator_fifo.sv -----
module tb_keyboard_scancode_translator_fifo;
    import kst_pkg::*;

    // beat kinds on the input channel
    localparam logic ACT_SCAN = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // keys used by name in the directed part
    localparam logic [7:0] KEY_A         = 8'h1E;
    localparam logic [7:0] KEY_1         = 8'h02;
    localparam logic [7:0] KEY_TABLE_ESC = 8'h50;
    localparam logic [7:0] FIELD_MIN     = 8'h00;
    localparam logic [7:0] FIELD_MAX     = 8'hFF;

    // character ranges for caps and ctrl handling
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_BEATS  = 340;

    typedef struct packed {
        logic       led_write;
        logic [2:0] led_value;
        logic       pop_valid;
        logic [7:0] pop_byte;
        logic       event_pressed;
        logic [6:0] event_code;
        logic       shift_down;
        logic       ctrl_down;
        logic       alt_down;
        logic       dropped_oldest;
    } t_key_result;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_action    = ACT_SCAN;
    logic [7:0] i_scan_byte = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_led_write;
    logic [2:0] o_led_value;
    logic       o_pop_valid;
    logic [7:0] o_pop_byte;
    logic       o_event_pressed;
    logic [6:0] o_event_code;
    logic       o_shift_down;
    logic       o_ctrl_down;
    logic       o_alt_down;
    logic       o_dropped_oldest;

    keyboard_scancode_translator_fifo dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_scan_byte      (i_scan_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_led_write      (o_led_write),
        .o_led_value      (o_led_value),
        .o_pop_valid      (o_pop_valid),
        .o_pop_byte       (o_pop_byte),
        .o_event_pressed  (o_event_pressed),
        .o_event_code     (o_event_code),
        .o_shift_down     (o_shift_down),
        .o_ctrl_down      (o_ctrl_down),
        .o_alt_down       (o_alt_down),
        .o_dropped_oldest (o_dropped_oldest)
    );

    // shadow state of the translator
    logic [7:0]  model_ring [0:KST_RING_DEPTH-1];
    int unsigned rd_idx = 0;
    int unsigned wr_idx = 0;
    logic [2:0]  mod_state  = 3'b000;
    logic [2:0]  lock_state = 3'b000;

    t_key_result expected_events [$];
    int unsigned error_count  = 0;
    int unsigned beats_sent   = 0;
    int unsigned cycle_count  = 0;

    // idling controls shared with the receiver
    bit          sender_idle_on = 1'b1;
    bit          recv_idle_on   = 1'b1;
    int unsigned hold_requests  = 0;
    int unsigned holds_served   = 0;
    int unsigned hold_left      = 0;
    int unsigned burst_left     = 0;

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL keyboard_scancode_translator_fifo");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // write one byte into the shadow ring, dropping the oldest when full
    function automatic logic ring_store_byte(input logic [7:0] b);
        int unsigned nxt;
        logic        dropped;
        nxt     = (wr_idx + 1) % KST_RING_DEPTH;
        dropped = (nxt == rd_idx);
        if (dropped) begin
            rd_idx = (rd_idx + 1) % KST_RING_DEPTH;
        end
        model_ring[wr_idx] = b;
        wr_idx             = nxt;
        return dropped;
    endfunction

    // table lookup with caps lock case flip
    function automatic logic [7:0] key_to_char(input logic [7:0] code);
        logic       shifted;
        logic       caps;
        logic [7:0] c;
        shifted = (mod_state & MOD_SHIFT) != 3'b000;
        caps    = (lock_state & LOCK_CAPS) != 3'b000;
        if (code >= K_TABLE_END) begin
            return 8'h00;
        end
        c = shifted ? UPPER_MAP[int'(code)] : PLAIN_MAP[int'(code)];
        if (caps && c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            c = c - CASE_DELTA;
        end else if (caps && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z && !shifted) begin
            c = c + CASE_DELTA;
        end
        return c;
    endfunction

    // expected result of one accepted beat
    task automatic predict_key_event(input logic act, input logic [7:0] sb);
        t_key_result r;
        logic [7:0]  c;
        logic [7:0]  code;
        r    = '0;
        code = sb & ~RELEASE_BIT;
        if (act == ACT_POP) begin
            if (rd_idx != wr_idx) begin
                r.pop_byte = model_ring[rd_idx];
                rd_idx     = (rd_idx + 1) % KST_RING_DEPTH;
            end
            if (r.pop_byte != 8'h00) begin
                r.pop_valid     = 1'b1;
                r.event_pressed = (r.pop_byte & RELEASE_BIT) == 8'h00;
            end
            r.event_code = r.pop_byte[6:0];
        end else if ((sb & RELEASE_BIT) != 8'h00) begin
            if (code == K_LSHIFT || code == K_RSHIFT) begin
                mod_state &= ~MOD_SHIFT;
            end else if (code == K_CTRL) begin
                mod_state &= ~MOD_CTRL;
            end else if (code == K_ALT) begin
                mod_state &= ~MOD_ALT;
            end
        end else if (sb == K_LSHIFT || sb == K_RSHIFT) begin
            mod_state |= MOD_SHIFT;
        end else if (sb == K_CTRL) begin
            mod_state |= MOD_CTRL;
        end else if (sb == K_ALT) begin
            mod_state |= MOD_ALT;
        end else if (sb == K_CAPS) begin
            lock_state ^= LOCK_CAPS;
            r.led_write = 1'b1;
        end else if (sb == K_NUM) begin
            lock_state ^= LOCK_NUM;
            r.led_write = 1'b1;
        end else if (sb == K_SCROLL) begin
            lock_state ^= LOCK_SCROLL;
            r.led_write = 1'b1;
        end else begin
            c = key_to_char(sb);
            if ((mod_state & MOD_CTRL) != 3'b000 && c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
                c = c - CHAR_LOWER_A + 8'd1;
            end
            if (c != 8'h00) begin
                r.dropped_oldest = ring_store_byte(c);
            end
            if (ring_store_byte(sb)) begin
                r.dropped_oldest = 1'b1;
            end
        end
        r.led_value  = lock_state;
        r.shift_down = (mod_state & MOD_SHIFT) != 3'b000;
        r.ctrl_down  = (mod_state & MOD_CTRL) != 3'b000;
        r.alt_down   = (mod_state & MOD_ALT) != 3'b000;
        expected_events.push_back(r);
    endtask

    // compare one accepted output beat with the oldest expectation
    task automatic check_key_result;
        t_key_result want;
        if (expected_events.size() == 0) begin
            report_mismatch("output beat with nothing pending", o_pop_byte, 8'h00);
            return;
        end
        want = expected_events.pop_front();
        check_field("led_write", o_led_write, want.led_write);
        check_field("led_value", o_led_value, want.led_value);
        check_field("pop_valid", o_pop_valid, want.pop_valid);
        check_field("pop_byte", o_pop_byte, want.pop_byte);
        check_field("event_pressed", o_event_pressed, want.event_pressed);
        check_field("event_code", o_event_code, want.event_code);
        check_field("shift_down", o_shift_down, want.shift_down);
        check_field("ctrl_down", o_ctrl_down, want.ctrl_down);
        check_field("alt_down", o_alt_down, want.alt_down);
        check_field("dropped_oldest", o_dropped_oldest, want.dropped_oldest);
    endtask

    // receiver: check accepted beats, drive stall bursts and long holds
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            check_key_result();
        end
        if (hold_requests != holds_served) begin
            hold_left = HOLD_CYCLES;
            holds_served++;
        end else if (hold_left > 0) begin
            hold_left--;
        end else if (burst_left > 0) begin
            burst_left--;
        end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(1, 17);
        end
        i_out_stall <= (hold_left > 0) || (burst_left > 0);
    end

    // offer one beat and wait for it to be taken
    task automatic send_key_beat(input logic act, input logic [7:0] sb);
        if (sender_idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_scan_byte <= sb;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_key_event(act, sb);
        beats_sent++;
    endtask

    task automatic pause_until_drained;
        i_in_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
    endtask

    // key that mostly yields a character, letters favored
    function automatic logic [7:0] random_char_key();
        logic [7:0] code;
        if ($urandom_range(0, 1) == 0) begin
            code = 8'($urandom_range(8'h10, 8'h32));
        end else begin
            code = 8'($urandom_range(8'h02, 8'h39));
        end
        if (code == K_LSHIFT || code == K_RSHIFT || code == K_CTRL || code == K_ALT) begin
            code = KEY_A;
        end
        return code;
    endfunction

    // modifiers held around a run of character keys, pops interleaved
    task automatic type_word;
        logic       use_shift;
        logic       use_ctrl;
        logic       use_alt;
        logic [7:0] shift_key;
        logic [7:0] key;
        use_shift = $urandom_range(0, 2) == 0;
        use_ctrl  = $urandom_range(0, 5) == 0;
        use_alt   = $urandom_range(0, 7) == 0;
        shift_key = $urandom_range(0, 1) ? K_LSHIFT : K_RSHIFT;
        if (use_shift) send_key_beat(ACT_SCAN, shift_key);
        if (use_ctrl)  send_key_beat(ACT_SCAN, K_CTRL);
        if (use_alt)   send_key_beat(ACT_SCAN, K_ALT);
        repeat ($urandom_range(1, 8)) begin
            key = random_char_key();
            send_key_beat(ACT_SCAN, key);
            if ($urandom_range(0, 2) == 0) send_key_beat(ACT_SCAN, key | RELEASE_BIT);
            if ($urandom_range(0, 1) == 0) send_key_beat(ACT_POP, 8'($urandom));
        end
        if (use_shift) send_key_beat(ACT_SCAN, shift_key | RELEASE_BIT);
        if (use_ctrl)  send_key_beat(ACT_SCAN, K_CTRL | RELEASE_BIT);
        if (use_alt)   send_key_beat(ACT_SCAN, K_ALT | RELEASE_BIT);
    endtask

    // field extremes, every key class, empty and zero pops
    task automatic test_directed_keys;
        send_key_beat(ACT_POP, FIELD_MIN);               // pop from an empty ring
        send_key_beat(ACT_SCAN, FIELD_MIN);              // code zero, no character
        send_key_beat(ACT_POP, FIELD_MAX);               // stored zero byte popped
        send_key_beat(ACT_SCAN, FIELD_MAX);              // release of a plain key
        send_key_beat(ACT_SCAN, RELEASE_BIT);
        send_key_beat(ACT_SCAN, FIELD_MAX & ~RELEASE_BIT); // press above the table
        send_key_beat(ACT_SCAN, K_TABLE_END);
        send_key_beat(ACT_SCAN, KEY_A);
        send_key_beat(ACT_SCAN, K_LSHIFT);
        send_key_beat(ACT_SCAN, KEY_1);
        send_key_beat(ACT_SCAN, K_CAPS);
        send_key_beat(ACT_SCAN, KEY_A);                  // shift with caps stays upper
        send_key_beat(ACT_SCAN, K_LSHIFT | RELEASE_BIT);
        send_key_beat(ACT_SCAN, KEY_A);                  // caps alone gives upper
        send_key_beat(ACT_SCAN, K_CTRL);
        send_key_beat(ACT_SCAN, KEY_A);                  // ctrl leaves upper case alone
        send_key_beat(ACT_SCAN, K_CAPS);
        send_key_beat(ACT_SCAN, KEY_A);                  // ctrl maps lower case letter
        send_key_beat(ACT_SCAN, K_NUM);
        send_key_beat(ACT_SCAN, K_SCROLL);
        send_key_beat(ACT_SCAN, K_ALT);
        send_key_beat(ACT_SCAN, K_RSHIFT);
        send_key_beat(ACT_SCAN, KEY_TABLE_ESC);
        send_key_beat(ACT_SCAN, K_RSHIFT | RELEASE_BIT);
        send_key_beat(ACT_SCAN, K_CTRL | RELEASE_BIT);
        send_key_beat(ACT_SCAN, K_ALT | RELEASE_BIT);
        repeat (3) send_key_beat(ACT_POP, 8'($urandom));
    endtask

    // fill past capacity so pushes drop the oldest, then pop some back
    task automatic test_ring_overflow;
        repeat (270) send_key_beat(ACT_SCAN, random_char_key());
        repeat (60) send_key_beat(ACT_POP, 8'($urandom));
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_output_backpressure;
        sender_idle_on = 1'b0;
        hold_requests++;
        repeat (30) begin
            if ($urandom_range(0, 2) == 0) begin
                send_key_beat(ACT_POP, 8'($urandom));
            end else begin
                send_key_beat(ACT_SCAN, random_char_key());
            end
        end
        sender_idle_on = 1'b1;
    endtask

    // sender goes quiet until every result is back
    task automatic test_drain_pause;
        type_word();
        pause_until_drained();
        type_word();
        send_key_beat(ACT_POP, 8'($urandom));
    endtask

    // mostly typing sequences, some locks, pops, noise and broken sequences
    task automatic test_random_typing(input int unsigned count);
        int unsigned stop_at;
        int          sel;
        stop_at = beats_sent + count;
        while (beats_sent < stop_at) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1, 2, 3, 4, 5: begin
                    type_word();
                end
                6: begin
                    case ($urandom_range(0, 2))
                        0: send_key_beat(ACT_SCAN, K_CAPS);
                        1: send_key_beat(ACT_SCAN, K_NUM);
                        default: send_key_beat(ACT_SCAN, K_SCROLL);
                    endcase
                end
                7: begin
                    repeat ($urandom_range(1, 6)) send_key_beat(ACT_POP, 8'($urandom));
                end
                8: begin
                    send_key_beat(ACT_SCAN, 8'($urandom));
                end
                default: begin
                    // modifier pressed or released out of order
                    case ($urandom_range(0, 3))
                        0: send_key_beat(ACT_SCAN, K_LSHIFT);
                        1: send_key_beat(ACT_SCAN, K_RSHIFT | RELEASE_BIT);
                        2: send_key_beat(ACT_SCAN, K_CTRL | (8'($urandom) & RELEASE_BIT));
                        default: send_key_beat(ACT_SCAN, K_ALT | (8'($urandom) & RELEASE_BIT));
                    endcase
                end
            endcase
        end
    endtask

    // closing stretch with no idling on either side
    task automatic test_no_idle_tail;
        sender_idle_on = 1'b0;
        recv_idle_on   = 1'b0;
        test_random_typing(40);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_keys();
        test_ring_overflow();
        test_output_backpressure();
        test_drain_pause();
        test_random_typing(RANDOM_BEATS);
        test_no_idle_tail();
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS keyboard_scancode_translator_fifo");
        end else begin
            $display("FAIL keyboard_scancode_translator_fifo");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/kst_pkg.sv
src/kst_ram.sv
src/kst_front.sv
src/kst_queue.sv
src/kst_back.sv
src/keyboard_scancode_translator_fifo.sv
sim/tb_keyboard_scancode_translator_fifo.sv
